// ----- rtl/core/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types and fixed constants of the receive-side frame parser.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // Parser phase, one-hot coded.
   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXTLEN  = 6'b000100,
      PH_KEY     = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_SKIP    = 6'b100000
   } phase_type;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_SHORT = 2'd1;
   localparam status_type STATUS_CLOSE = 2'd2;

   localparam logic [3:0] OPCODE_CLOSE = 4'h8;
   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;
   localparam logic [3:0] EXT16_BYTES  = 4'd2;
   localparam logic [3:0] EXT64_BYTES  = 4'd8;

endpackage

// ----- rtl/core/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses one received frame per buffer and delivers its unmasked payload.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Contents
//  --------+-----------+----------------------+-------------------------------
//  req_    | in        | req_valid/req_stall  | one buffer byte, last-byte flag
//  rsp_    | out       | rsp_valid/rsp_stall  | payload byte or end/drop status
//
// One byte is taken in every cycle with req_stall low; the whole per-byte
// update of the parser state (with the 64-bit length count) is done in that
// cycle. A result appears in the output register in the cycle after the
// transfer of the byte that caused it; other bytes leave it untouched.
// req_stall is raised only while a result waits in the output register and
// the receiver stalls; a result that is being taken frees the slot at once.
// Reset is synchronous and active high; it returns the parser to the first
// header byte and empties the output register.
//
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_end_of_buffer,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic       rsp_frame_end,
   output logic [1:0] rsp_frame_status
);

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_left_ff, hdr_left_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic        mask_present_ff, mask_present_in;
   logic [1:0]  key_pos_ff, key_pos_in;
   logic        close_seen_ff, close_seen_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_has_ff, out_has_in;
   logic        out_end_ff, out_end_in;
   status_type  out_status_ff, out_status_in;

   logic        accept;
   logic        emit;
   logic        ended;
   logic        length_done;
   logic        payload_start;
   logic        complete;
   logic [7:0]  key_byte;

   // The slot is free unless a result sits there and is being held back.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Key byte for the current payload position; zero for unmasked frames.
   assign key_byte  = mask_present_ff ? mask_key_ff[{key_pos_ff, 3'b000} +: 8] : 8'h00;

   always_comb begin
      phase_in        = phase_ff;
      hdr_left_in     = hdr_left_ff;
      remaining_in    = remaining_ff;
      mask_key_in     = mask_key_ff;
      mask_present_in = mask_present_ff;
      key_pos_in      = key_pos_ff;
      close_seen_in   = close_seen_ff;
      emit            = 1'b0;
      ended           = 1'b0;
      length_done     = 1'b0;
      payload_start   = 1'b0;
      complete        = 1'b0;
      out_byte_in     = 8'h00;
      out_has_in      = 1'b0;
      out_end_in      = 1'b0;
      out_status_in   = STATUS_OK;

      unique case (phase_ff)
         PH_HDR1: begin
            // Mask bit and 7-bit length; 126 and 127 announce an extended length.
            mask_present_in = req_rx_byte[7];
            remaining_in    = '0;
            if (req_rx_byte[6:0] == LEN_EXT16) begin
               hdr_left_in = EXT16_BYTES;
               phase_in    = PH_EXTLEN;
            end else if (req_rx_byte[6:0] == LEN_EXT64) begin
               hdr_left_in = EXT64_BYTES;
               phase_in    = PH_EXTLEN;
            end else begin
               remaining_in = {57'd0, req_rx_byte[6:0]};
               length_done  = 1'b1;
            end
         end
         PH_EXTLEN: begin
            // Extended length arrives most significant byte first.
            remaining_in = {remaining_ff[55:0], req_rx_byte};
            hdr_left_in  = 4'(hdr_left_ff - 4'd1);
            length_done  = (hdr_left_ff == 4'd1);
         end
         PH_KEY: begin
            mask_key_in[{key_pos_ff, 3'b000} +: 8] = req_rx_byte;
            key_pos_in    = 2'(key_pos_ff + 2'd1);
            payload_start = (key_pos_ff == 2'd3);
         end
         PH_PAYLOAD: begin
            key_pos_in   = 2'(key_pos_ff + 2'd1);
            remaining_in = 64'(remaining_ff - 64'd1);
            emit         = 1'b1;
            out_byte_in  = req_rx_byte ^ key_byte;
            out_has_in   = 1'b1;
            if (remaining_ff == 64'd1) begin
               out_end_in    = 1'b1;
               ended         = 1'b1;
               phase_in      = PH_SKIP;
               close_seen_in = 1'b0;
            end
         end
         PH_SKIP: begin
            // Bytes after a finished or refused frame are ignored.
         end
         default: begin
            // First header byte: only the opcode matters, FIN is ignored.
            if (!req_end_of_buffer) begin
               if (req_rx_byte[3:0] == OPCODE_CLOSE) begin
                  close_seen_in = 1'b1;
                  phase_in      = PH_SKIP;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
         end
      endcase

      // Length known: either collect the mask key or go straight to payload.
      if (length_done) begin
         if (mask_present_in) begin
            phase_in    = PH_KEY;
            key_pos_in  = 2'd0;
            mask_key_in = '0;
         end else begin
            payload_start = 1'b1;
         end
      end

      // An empty payload finishes the frame with a single completion result.
      if (payload_start) begin
         key_pos_in = 2'd0;
         if (remaining_in == 64'd0) begin
            emit          = 1'b1;
            out_end_in    = 1'b1;
            ended         = 1'b1;
            phase_in      = PH_SKIP;
            close_seen_in = 1'b0;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end

      // The last byte of a buffer either closes a finished frame silently or
      // replaces whatever it would have given by a drop result; the parser
      // then starts afresh for the next buffer.
      if (req_end_of_buffer) begin
         complete = ended || (phase_in == PH_SKIP && !close_seen_in);
         if (!complete) begin
            emit          = 1'b1;
            out_byte_in   = 8'h00;
            out_has_in    = 1'b0;
            out_end_in    = 1'b1;
            out_status_in = close_seen_in ? STATUS_CLOSE : STATUS_SHORT;
         end
         phase_in        = PH_HDR0;
         hdr_left_in     = '0;
         remaining_in    = '0;
         mask_key_in     = '0;
         mask_present_in = 1'b0;
         key_pos_in      = 2'd0;
         close_seen_in   = 1'b0;
      end
   end

   // Output register: loads on a transfer that gives a result, empties when
   // its result is taken.
   always_comb begin
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         hdr_left_ff     <= '0;
         remaining_ff    <= '0;
         mask_key_ff     <= '0;
         mask_present_ff <= 1'b0;
         key_pos_ff      <= 2'd0;
         close_seen_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff        <= phase_in;
            hdr_left_ff     <= hdr_left_in;
            remaining_ff    <= remaining_in;
            mask_key_ff     <= mask_key_in;
            mask_present_ff <= mask_present_in;
            key_pos_ff      <= key_pos_in;
            close_seen_ff   <= close_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_byte_ff   <= out_byte_in;
         out_has_ff    <= out_has_in;
         out_end_ff    <= out_end_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_has_byte     = out_has_ff;
   assign rsp_frame_end    = out_end_ff;
   assign rsp_frame_status = out_status_ff;

`ifndef SYNTHESIS
   // The last byte of a buffer always returns the parser to its start.
   a_eob_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_buffer |=> phase_ff == PH_HDR0)
      else $error("parser not restarted after last byte of buffer");

   // While payload is being delivered at least one byte is still due.
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remaining_ff != 64'd0)
      else $error("payload phase with zero bytes remaining");

   // A result without a payload byte is always the end of a frame or buffer.
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_has_ff |-> out_end_ff)
      else $error("empty result that does not end the frame");

   // Payload bytes always carry an ok status.
   a_byte_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_has_ff |-> out_status_ff == STATUS_OK)
      else $error("payload byte with drop status");
`endif

endmodule

// ----- tb/wsd_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket deframer checker
// Watches both channels of the deframer and models its parser. It queues the
// results that each accepted byte should cause and compares every result
// transfer against the oldest of them, field by field.
// ----------------------------------------------------------------------------
module wsd_frame_checker
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_end_of_buffer,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_payload_byte,
   input  logic       rsp_has_byte,
   input  logic       rsp_frame_end,
   input  logic [1:0] rsp_frame_status,
   output int         mismatches,
   output int         pending
);

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       frame_end;
      status_type frame_status;
   } deframed_type;

   deframed_type results_due[$];
   deframed_type want;

   // Model of the parser state.
   phase_type   phase;
   logic [3:0]  ext_bytes_left;
   logic [63:0] bytes_left;
   logic [31:0] key;
   logic        masked;
   logic [1:0]  key_index;
   status_type  drop_status;

   task automatic clear_parser();
      phase          = PH_HDR0;
      ext_bytes_left = '0;
      bytes_left     = '0;
      key            = '0;
      masked         = 1'b0;
      key_index      = '0;
      drop_status    = STATUS_OK;
   endtask

   // Sets empty when the frame has no payload and is complete at once.
   task automatic open_payload(output bit empty);
      key_index = '0;
      empty     = (bytes_left == 0);
      if (empty) begin
         phase       = PH_SKIP;
         drop_status = STATUS_OK;
      end else begin
         phase = PH_PAYLOAD;
      end
   endtask

   task automatic after_length(output bit empty);
      if (masked) begin
         phase     = PH_KEY;
         key_index = '0;
         key       = '0;
         empty     = 1'b0;
      end else begin
         open_payload(empty);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b, input logic last);
      deframed_type res;
      bit           emit;
      bit           ended;
      bit           empty;
      logic [7:0]   pad;
      res   = '0;
      emit  = 1'b0;
      ended = 1'b0;
      empty = 1'b0;
      case (phase)
         PH_HDR1: begin
            masked     = b[7];
            bytes_left = '0;
            if (b[6:0] == LEN_EXT16) begin
               ext_bytes_left = EXT16_BYTES;
               phase          = PH_EXTLEN;
            end else if (b[6:0] == LEN_EXT64) begin
               ext_bytes_left = EXT64_BYTES;
               phase          = PH_EXTLEN;
            end else begin
               bytes_left = {57'd0, b[6:0]};
               after_length(empty);
            end
         end
         PH_EXTLEN: begin
            bytes_left     = {bytes_left[55:0], b};
            ext_bytes_left = ext_bytes_left - 4'd1;
            if (ext_bytes_left == 0) after_length(empty);
         end
         PH_KEY: begin
            key[8*key_index +: 8] = b;
            key_index             = key_index + 2'd1;
            if (key_index == 0) open_payload(empty);
         end
         PH_PAYLOAD: begin
            pad              = masked ? key[8*key_index +: 8] : 8'h00;
            key_index        = key_index + 2'd1;
            bytes_left       = bytes_left - 64'd1;
            res.payload_byte = b ^ pad;
            res.has_byte     = 1'b1;
            emit             = 1'b1;
            if (bytes_left == 0) begin
               res.frame_end = 1'b1;
               ended         = 1'b1;
               phase         = PH_SKIP;
               drop_status   = STATUS_OK;
            end
         end
         PH_SKIP: ;
         default: begin
            if (!last) begin
               if (b[3:0] == OPCODE_CLOSE) begin
                  drop_status = STATUS_CLOSE;
                  phase       = PH_SKIP;
               end else begin
                  phase = PH_HDR1;
               end
            end
         end
      endcase
      if (empty) begin
         res.frame_end = 1'b1;
         emit          = 1'b1;
         ended         = 1'b1;
      end
      // The last byte of an unfinished buffer replaces anything else.
      if (last) begin
         if (!(ended || (phase == PH_SKIP && drop_status == STATUS_OK))) begin
            res              = '0;
            res.frame_end    = 1'b1;
            res.frame_status = (drop_status == STATUS_CLOSE) ? STATUS_CLOSE : STATUS_SHORT;
            emit             = 1'b1;
         end
         clear_parser();
      end
      if (emit) results_due.push_back(res);
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      pending    = 0;
      clear_parser();
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("unexpected result: byte 0x%0h has_byte %0b frame_end %0b status %0d",
                      rsp_payload_byte, rsp_has_byte, rsp_frame_end, rsp_frame_status);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               check_field("payload_byte", want.payload_byte, rsp_payload_byte);
               check_field("has_byte", {7'd0, want.has_byte}, {7'd0, rsp_has_byte});
               check_field("frame_end", {7'd0, want.frame_end}, {7'd0, rsp_frame_end});
               check_field("frame_status", {6'd0, want.frame_status},
                           {6'd0, rsp_frame_status});
            end
         end
         if (req_valid && !req_stall) deframe_byte(req_rx_byte, req_end_of_buffer);
         pending <= results_due.size();
      end
   end

endmodule

// ----- tb/tb_websocket_frame_deframer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends received buffers byte by byte into the deframer: a few hand-built
// frames first, then random well-formed, close, truncated, oversized and
// junk buffers. Both sides idle at random, and once the receiver holds off
// long enough to back the block up. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
   import wsd_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1550;
   localparam int MAX_IDLE     = 6;
   localparam int HOLD_AFTER   = 250;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int FRAME_MAX    = 512;

   // Header bits and opcodes used by the hand-built frames.
   localparam logic [7:0] FIN_BIT       = 8'h80;
   localparam logic [7:0] MASK_BIT      = 8'h80;
   localparam logic [3:0] OPCODE_CONT   = 4'h0;
   localparam logic [3:0] OPCODE_TEXT   = 4'h1;
   localparam logic [3:0] OPCODE_BINARY = 4'h2;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte       = 8'h00;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_byte;
   logic       rsp_frame_end;
   logic [1:0] rsp_frame_status;

   int         mismatches;
   int         pending;
   int         cycle_count       = 0;

   // The buffer being built and its length.
   logic [7:0] frame_bytes [0:FRAME_MAX-1];
   int         frame_len;
   int         sent_bytes        = 0;
   int         random_items      = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   websocket_frame_deframer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_frame_status  (rsp_frame_status)
   );

   wsd_frame_checker frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_frame_status  (rsp_frame_status),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   // Watchdog: a run that never drains ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("websocket_frame_deframer: mismatch");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      frame_bytes[frame_len] = b;
      frame_len++;
   endtask

   // Offers one byte after a random gap and holds it, unchanged, until the
   // transfer happens. Entered and left at a falling edge. Every fourth run
   // of 128 bytes goes out back to back with no gaps at all.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = (((sent_bytes / 128) % 4) == 3) ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_rx_byte       <= b;
      req_end_of_buffer <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_bytes++;
      @(negedge clock);
   endtask

   task automatic transmit_buffer();
      for (int i = 0; i < frame_len; i++) send_byte(frame_bytes[i], i == frame_len - 1);
   endtask

   // Builds one frame. Most lengths are short so that whole frames fit in
   // the run; when oversized is set the extended length is fully random and
   // the buffer carries only a few payload bytes, so it mostly ends early.
   task automatic build_frame(input logic [3:0] opcode, input bit oversized);
      int          len;
      int          code;
      logic        masked;
      logic [7:0]  top_bits;
      logic [63:0] ext;
      masked   = 1'($urandom_range(0, 1));
      top_bits = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            len  = $urandom_range(0, 20);
            code = len;
         end
         5: begin
            len  = $urandom_range(0, 125);
            code = len;
         end
         6, 7: begin
            code = int'(LEN_EXT16);
            len  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300)
                                                : $urandom_range(0, 40);
         end
         default: begin
            code = int'(LEN_EXT64);
            len  = $urandom_range(0, 40);
         end
      endcase
      ext = 64'(len);
      if (oversized) begin
         code = $urandom_range(0, 1) ? int'(LEN_EXT64) : int'(LEN_EXT16);
         ext  = {$urandom, $urandom};
         len  = $urandom_range(0, 10);
      end
      push_byte({top_bits[7:4], opcode});
      push_byte({masked, code[6:0]});
      if (code == LEN_EXT16) begin
         push_byte(ext[15:8]);
         push_byte(ext[7:0]);
      end else if (code == LEN_EXT64) begin
         for (int i = 7; i >= 0; i--) push_byte(ext[8*i +: 8]);
      end
      if (masked) repeat (4) push_byte(8'($urandom_range(0, 255)));
      repeat (len) push_byte(8'($urandom_range(0, 255)));
      if (!oversized) repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
   endtask

   // Receiver: after each result transfer it stalls for a random number of
   // cycles, except in every fourth run of 100 results. Once, after a few
   // hundred results, it holds off long enough for the output register to
   // fill and the block to stall its input while the sender keeps offering.
   initial begin : rsp_side
      int gap;
      int taken;
      bit held;
      taken = 0;
      held  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && taken == HOLD_AFTER) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end else begin
            gap = (((taken / 100) % 4) == 3) ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   // Sender: reset, the hand-built buffers, the random buffers, then drain.
   initial begin : req_side
      int         pick;
      logic [3:0] opcode;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A one-byte buffer counts as too short, even with a close opcode.
      frame_len = 0;
      push_byte(FIN_BIT | OPCODE_CLOSE);
      transmit_buffer();

      // Zero-length payload, unmasked: completes right after the header.
      frame_len = 0;
      push_byte(FIN_BIT | OPCODE_TEXT);
      push_byte(8'h00);
      transmit_buffer();

      // Zero-length payload after a mask key, then one trailing byte.
      frame_len = 0;
      push_byte(FIN_BIT | OPCODE_BINARY);
      push_byte(MASK_BIT);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h80);
      push_byte(8'h01);
      push_byte(8'hFF);
      transmit_buffer();

      // Close opcode: the rest of the buffer is skipped and the last byte
      // reports the close.
      frame_len = 0;
      push_byte(FIN_BIT | OPCODE_CLOSE);
      push_byte(MASK_BIT | LEN_EXT64);
      push_byte(8'hFF);
      transmit_buffer();

      // Masked two-byte payload, continuation opcode with FIN clear.
      frame_len = 0;
      push_byte({4'h0, OPCODE_CONT});
      push_byte(MASK_BIT | 8'd2);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'hA5);
      push_byte(8'h5A);
      push_byte(8'h00);
      push_byte(8'hFF);
      transmit_buffer();

      // 16-bit extended length of one, whose only byte is also the last.
      frame_len = 0;
      push_byte(FIN_BIT | OPCODE_BINARY);
      push_byte({1'b0, LEN_EXT16});
      push_byte(8'h00);
      push_byte(8'h01);
      push_byte(8'hFF);
      transmit_buffer();

      // Largest 7-bit length, cut short after one payload byte.
      frame_len = 0;
      push_byte({4'h0, OPCODE_TEXT});
      push_byte(8'd125);
      push_byte(8'h00);
      transmit_buffer();

      while (random_items < RANDOM_ITEMS) begin
         frame_len = 0;
         opcode    = 4'($urandom_range(0, 15));
         while (opcode == OPCODE_CLOSE) opcode = 4'($urandom_range(0, 15));
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            build_frame(opcode, 1'b0);
         end else if (pick < 70) begin
            // Only the close report matters; the bytes behind it are skipped.
            build_frame(OPCODE_CLOSE, 1'b0);
         end else if (pick < 82) begin
            // A well-formed frame whose buffer ends at a random byte.
            build_frame(opcode, 1'b0);
            frame_len = $urandom_range(1, frame_len);
         end else if (pick < 88) begin
            build_frame(opcode, 1'b1);
         end else begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
         end
         transmit_buffer();
         random_items += frame_len;
      end
      req_valid <= 1'b0;

      // Let every expected result arrive, then give any stray one a chance
      // to show up before the verdict.
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("websocket_frame_deframer: match");
      end else begin
         $display("websocket_frame_deframer: mismatch");
      end
      $finish;
   end

endmodule
